// ----- hdl/selective_repeat_sender_window_assert.svh -----
// Assertion macros for the selective repeat sender window.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SRSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SRSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/srsw_pkg.sv -----
// Types and constants shared by the selective repeat sender window.
// No dependencies.
`default_nettype none
package srsw_pkg;

  localparam int unsigned SEQ_SPACE = 16;
  localparam int unsigned SEQ_W     = 4;
  localparam logic [3:0]  WIN_MAX   = 4'(SEQ_SPACE / 2);
  localparam logic [3:0]  WIN_RESET = 4'd4;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_ACK     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SEND,
    CMD_TIMEOUT,
    CMD_ACK
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_SEND = 3'd1,
    ACT_RETX = 3'd2,
    ACT_FULL = 3'd3,
    ACT_ACK  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLIDE
  } state_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [SEQ_W-1:0] seq;
  } cmd_t;

  typedef struct packed {
    act_e             action;
    logic [SEQ_W-1:0] action_seq;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] next_seq;
    logic [3:0]       in_flight;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/srsw_front.sv -----
// Front end: takes input beats, decodes them into commands and queues them.
// Depends on srsw_pkg.
`default_nettype none
module srsw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode_i,
  input  logic [3:0]    seq_number_i,
  input  logic          ack_valid_i,
  output logic          cmd_valid_o,
  output srsw_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import srsw_pkg::*;

  cmd_t       q_q [2];
  cmd_t       cmd_d;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_d.seq  = seq_number_i;
    cmd_d.kind = CMD_NOP;
    unique case (opcode_i)
      OP_SEND:    cmd_d.kind = CMD_SEND;
      OP_TIMEOUT: cmd_d.kind = CMD_TIMEOUT;
      OP_ACK:     cmd_d.kind = ack_valid_i ? CMD_ACK : CMD_NOP;
      default:    cmd_d.kind = CMD_NOP;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_q[wr_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) wr_q <= ~wr_q;
      if (pop_ok)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srsw_back.sv -----
// Back end: window state, command execution, base slide and result queue.
// Depends on srsw_pkg.
`default_nettype none
module srsw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     window_size_i,
  input  logic           cmd_valid_i,
  input  srsw_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output srsw_pkg::res_t res_o
);
  import srsw_pkg::*;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  logic [3:0]       win_cfg_q;
  logic [SEQ_W-1:0] base_q, base_d, send_q, send_d;
  logic [SEQ_SPACE-1:0] pend_q;
  logic             pend_set, pend_clr, pend_rd;
  logic [SEQ_W-1:0] rd_addr, flight, off;
  logic [3:0]       win;
  act_e             act;
  logic [SEQ_W-1:0] aseq;
  logic             res_push, res_pop;
  res_t             res_d;
  res_t             rq_q [2];
  logic             rwr_q, rrd_q;
  logic [1:0]       rcnt_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (win_cfg_q == 4'd0)        win = 4'd1;
    else if (win_cfg_q > WIN_MAX) win = WIN_MAX;
    else                          win = win_cfg_q;
  end

  assign rd_addr = (state_q == ST_SLIDE) ? base_q : cmd_q.seq;
  assign pend_rd = pend_q[rd_addr];
  assign flight  = send_q - base_q;
  assign off     = cmd_q.seq - base_q;

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    send_d    = send_q;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    res_push  = 1'b0;
    cmd_pop_o = 1'b0;
    act       = ACT_NONE;
    aseq      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && rcnt_q != 2'd2) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_push = 1'b1;
        state_d  = ST_IDLE;
        case (cmd_q.kind)
          CMD_SEND: begin
            if (4'(flight) < win) begin
              pend_set = 1'b1;
              send_d   = send_q + 1'b1;
              act      = ACT_SEND;
              aseq     = send_q;
            end else begin
              act = ACT_FULL;
            end
          end
          CMD_TIMEOUT: begin
            if (off < flight && pend_rd) begin
              act  = ACT_RETX;
              aseq = cmd_q.seq;
            end
          end
          CMD_ACK: begin
            if (4'(off) < win && off < flight) begin
              pend_clr = 1'b1;
              res_push = 1'b0;
              state_d  = ST_SLIDE;
            end
          end
          default: act = ACT_NONE;
        endcase
      end
      ST_SLIDE: begin
        if (base_q != send_q && !pend_rd) begin
          base_d = base_q + 1'b1;
        end else begin
          res_push = 1'b1;
          act      = ACT_ACK;
          aseq     = cmd_q.seq;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    res_d.action      = act;
    res_d.action_seq  = aseq;
    res_d.window_base = base_d;
    res_d.next_seq    = send_d;
    res_d.in_flight   = 4'(send_d - base_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      base_q    <= '0;
      send_q    <= '0;
      pend_q    <= '0;
      win_cfg_q <= WIN_RESET;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      send_q  <= send_d;
      if (pend_set) pend_q[send_q]    <= 1'b1;
      if (pend_clr) pend_q[cmd_q.seq] <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) win_cfg_q <= window_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (res_push)  rq_q[rwr_q] <= res_d;
  end

  // result queue
  assign empty   = (rcnt_q == 2'd0);
  assign res_o   = rq_q[rrd_q];
  assign res_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (res_push) rwr_q <= ~rwr_q;
      if (res_pop)  rrd_q <= ~rrd_q;
      rcnt_q <= rcnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/selective_repeat_sender_window.sv -----
// Top level of the selective repeat sender window.
// Depends on srsw_pkg, srsw_front and srsw_back.
//
// Input side is a queue: an event beat (opcode, seq_number, ack_valid) is
// taken when push is high and full is low. A two-entry command queue sits
// behind it, so events can be taken while the back end is busy.
// Result side is a queue: while empty is low the oldest result is on the
// result ports; pop takes it. A two-entry result queue holds results while
// the receiver stalls; once it is full the back end stops draining commands
// and full rises when the command queue fills too.
// The window size register is written over cfg_valid_i/cfg_ready_o; ready
// is always high. Write it only while the block is idle.
// The back end takes an accepted event from the command queue while idle; the
// exec state then writes its result. An accepted ack goes on to the slide
// state, which moves the base over 0 to 8 slots, reading one pending flag per
// cycle, before the result is written; the back end works on one command at a time.
// Reset: base and next sequence 0, no number outstanding, window size 4,
// both queues empty.
`default_nettype none
module selective_repeat_sender_window (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [3:0] seq_number_i,
  input  logic       ack_valid_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] action_o,
  output logic [3:0] action_seq_o,
  output logic [3:0] window_base_o,
  output logic [3:0] next_seq_o,
  output logic [3:0] in_flight_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] window_size_i
);
  import srsw_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  srsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .seq_number_i(seq_number_i),
    .ack_valid_i (ack_valid_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  srsw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .window_size_i(window_size_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign action_o      = res.action;
  assign action_seq_o  = res.action_seq;
  assign window_base_o = res.window_base;
  assign next_seq_o    = res.next_seq;
  assign in_flight_o   = res.in_flight;

endmodule
`default_nettype wire

// ----- hdl/srsw_checker.sv -----
// Port-level checks for the selective repeat sender window, bound to the top.
// Depends on srsw_pkg and selective_repeat_sender_window_assert.svh.
`default_nettype none
`include "selective_repeat_sender_window_assert.svh"
module srsw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] action_o,
  input logic [3:0] action_seq_o,
  input logic [3:0] window_base_o,
  input logic [3:0] next_seq_o,
  input logic [3:0] in_flight_o
);
  import srsw_pkg::*;

  logic [3:0]  span;
  logic [3:0]  last_sent;
  logic        flight_ok, send_ok, no_act;
  logic [18:0] res_w;

  assign span      = next_seq_o - window_base_o;
  assign last_sent = next_seq_o - 4'd1;
  assign flight_ok = (in_flight_o == span) && (in_flight_o <= WIN_MAX);
  assign send_ok   = (action_seq_o == last_sent) && (in_flight_o != 4'd0);
  assign no_act    = (action_o == ACT_NONE) || (action_o == ACT_FULL);
  assign res_w     = {action_o, action_seq_o, window_base_o, next_seq_o, in_flight_o};

  `SRSW_ASSERT_IMP(a_flight, !empty, flight_ok, "in_flight mismatch")
  `SRSW_ASSERT_IMP(a_send_seq, !empty && action_o == ACT_SEND, send_ok, "send seq wrong")
  `SRSW_ASSERT_IMP(a_no_seq, !empty && no_act, action_seq_o == 4'd0, "stray seq")
  `SRSW_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(res_w), "result lost")

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);
`default_nettype wire
